// ===== rtl/core/uvsg_pkg.sv =====
// ----------------------------------------------------------------------------
// UV sphere vertex generator package
// Shared types, constants and helper functions of the vertex generator.
// ----------------------------------------------------------------------------
`default_nettype none

package uvsg_pkg;

   // Field widths.
   localparam int IDX_W  = 9;
   localparam int CNT_W  = 9;
   localparam int RAD_W  = 15;
   localparam int CSR_W  = 15;
   localparam int BASE_W = 17;
   localparam int TEX_W  = 17;
   localparam int OUT_W  = 16;

   // Register indices of the configuration port.
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RADIUS  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SECTORS = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_STACKS  = 2'd2;

   localparam logic [RAD_W-1:0] RADIUS_RST  = 15'd4506;
   localparam logic [CNT_W-1:0] SECTORS_RST = 9'd36;
   localparam logic [CNT_W-1:0] STACKS_RST  = 9'd18;

   // Long division: an integer quotient bit, then fractional bits in stages.
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = 9;
   localparam int DIV_FRAC   = DIV_STEPS * DIV_STAGES;
   localparam int QUO_W      = DIV_FRAC + 1;
   localparam int REM_W      = CNT_W + 1;

   // Rotation-mode CORDIC.
   localparam int CORDIC_STEPS  = 20;
   localparam int CORDIC_PER_ST = 2;
   localparam int CORDIC_STAGES = CORDIC_STEPS / CORDIC_PER_ST;
   localparam int CX_W          = 34;
   localparam int PH_W          = 32;
   localparam int TRIG_W        = 32;
   localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam int LANE_STACK  = 0;
   localparam int LANE_SECTOR = 1;

   typedef struct packed {
      logic [BASE_W-1:0] next_row_base;
      logic [BASE_W-1:0] row_base;
      logic              lower_tri_valid;
      logic              upper_tri_valid;
   } mesh_type;

   typedef struct packed {
      mesh_type         mesh;
      logic [TEX_W-1:0] tex_t;
      logic [TEX_W-1:0] tex_s;
   } vtx_side_type;

   function automatic logic signed [31:0] atan_entry(input int k);
      logic signed [31:0] a;
      case (k)
         0:  a = 32'sd536870912;
         1:  a = 32'sd316933406;
         2:  a = 32'sd167458907;
         3:  a = 32'sd85004756;
         4:  a = 32'sd42667331;
         5:  a = 32'sd21354465;
         6:  a = 32'sd10679838;
         7:  a = 32'sd5340245;
         8:  a = 32'sd2670163;
         9:  a = 32'sd1335087;
         10: a = 32'sd667544;
         11: a = 32'sd333772;
         12: a = 32'sd166886;
         13: a = 32'sd83443;
         14: a = 32'sd41722;
         15: a = 32'sd20861;
         16: a = 32'sd10430;
         17: a = 32'sd5215;
         18: a = 32'sd2608;
         19: a = 32'sd1304;
         default: a = 32'sd0;
      endcase
      return a;
   endfunction

   function automatic logic signed [OUT_W-1:0] sat16(input logic signed [63:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > 64'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -64'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/uvsg_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined fraction divider
// Two lanes of restoring long division n/d with n <= d, four quotient bits
// per stage, giving floor(n * 2^36 / d).
// ----------------------------------------------------------------------------
`default_nettype none

module uvsg_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_vld,
   input  logic [1:0][uvsg_pkg::CNT_W-1:0]        num,
   input  logic [1:0][uvsg_pkg::CNT_W-1:0]        den,
   input  uvsg_pkg::mesh_type                     mesh_in,
   output logic                                   out_vld,
   output logic [1:0][uvsg_pkg::QUO_W-1:0]        quo,
   output uvsg_pkg::mesh_type                     mesh_out
);
   import uvsg_pkg::*;

   logic [DIV_STAGES-1:0]        vld_ff;
   logic [1:0][REM_W-1:0]        rem_ff  [DIV_STAGES];
   logic [1:0][REM_W-1:0]        rem_in  [DIV_STAGES];
   logic [1:0][QUO_W-1:0]        quo_ff  [DIV_STAGES];
   logic [1:0][QUO_W-1:0]        quo_in  [DIV_STAGES];
   logic [1:0][CNT_W-1:0]        den_ff  [DIV_STAGES];
   logic [1:0][CNT_W-1:0]        den_in  [DIV_STAGES];
   mesh_type                     mesh_ff [DIV_STAGES];
   logic [1:0][REM_W-1:0]        src_rem [DIV_STAGES];
   logic [1:0][QUO_W-1:0]        src_quo [DIV_STAGES];
   logic [1:0][CNT_W-1:0]        src_den [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      for (genvar l = 0; l < 2; l++) begin : g_lane
         if (s == 0) begin : g_first
            // The quotient is one only when the numerator equals the divisor.
            assign src_quo[s][l] = QUO_W'(num[l] == den[l]);
            assign src_rem[s][l] = (num[l] == den[l]) ? '0 : REM_W'(num[l]);
            assign src_den[s][l] = den[l];
         end else begin : g_next
            assign src_quo[s][l] = quo_ff[s-1][l];
            assign src_rem[s][l] = rem_ff[s-1][l];
            assign src_den[s][l] = den_ff[s-1][l];
         end
      end

      always_comb begin
         logic [REM_W-1:0] r;
         logic [QUO_W-1:0] q;
         for (int l = 0; l < 2; l++) begin
            r = src_rem[s][l];
            q = src_quo[s][l];
            for (int k = 0; k < DIV_STEPS; k++) begin
               r = {r[REM_W-2:0], 1'b0};
               if (r >= {1'b0, src_den[s][l]}) begin
                  r = r - {1'b0, src_den[s][l]};
                  q = {q[QUO_W-2:0], 1'b1};
               end else begin
                  q = {q[QUO_W-2:0], 1'b0};
               end
            end
            rem_in[s][l] = r;
            quo_in[s][l] = q;
            den_in[s][l] = src_den[s][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DIV_STAGES-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff     <= rem_in;
         quo_ff     <= quo_in;
         den_ff     <= den_in;
         mesh_ff[0] <= mesh_in;
         for (int s = 1; s < DIV_STAGES; s++) begin
            mesh_ff[s] <= mesh_ff[s-1];
         end
      end
   end

   assign out_vld  = vld_ff[DIV_STAGES-1];
   assign quo      = quo_ff[DIV_STAGES-1];
   assign mesh_out = mesh_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/uvsg_cordic.sv =====
// ----------------------------------------------------------------------------
// Pipelined CORDIC sine and cosine
// Two lanes of 20 rotation steps, two per stage, then a quadrant fold stage.
// ----------------------------------------------------------------------------
`default_nettype none

module uvsg_cordic (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_vld,
   input  logic [1:0][uvsg_pkg::PH_W-1:0]        phase,
   input  uvsg_pkg::vtx_side_type                side_in,
   output logic                                  out_vld,
   output logic signed [uvsg_pkg::TRIG_W-1:0]    cos_out [2],
   output logic signed [uvsg_pkg::TRIG_W-1:0]    sin_out [2],
   output uvsg_pkg::vtx_side_type                side_out
);
   import uvsg_pkg::*;

   localparam int NST = CORDIC_STAGES + 1;

   logic [NST-1:0]            vld_ff;
   logic signed [CX_W-1:0]    x_ff   [CORDIC_STAGES][2];
   logic signed [CX_W-1:0]    x_in   [CORDIC_STAGES][2];
   logic signed [CX_W-1:0]    y_ff   [CORDIC_STAGES][2];
   logic signed [CX_W-1:0]    y_in   [CORDIC_STAGES][2];
   logic signed [PH_W-1:0]    z_ff   [CORDIC_STAGES][2];
   logic signed [PH_W-1:0]    z_in   [CORDIC_STAGES][2];
   logic [1:0]                quad_ff[CORDIC_STAGES][2];
   logic signed [CX_W-1:0]    src_x  [CORDIC_STAGES][2];
   logic signed [CX_W-1:0]    src_y  [CORDIC_STAGES][2];
   logic signed [PH_W-1:0]    src_z  [CORDIC_STAGES][2];
   logic [1:0]                src_q  [CORDIC_STAGES][2];
   vtx_side_type              side_ff[NST];
   logic signed [TRIG_W-1:0]  cos_ff [2];
   logic signed [TRIG_W-1:0]  cos_in [2];
   logic signed [TRIG_W-1:0]  sin_ff [2];
   logic signed [TRIG_W-1:0]  sin_in [2];

   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
      for (genvar l = 0; l < 2; l++) begin : g_lane
         if (s == 0) begin : g_first
            // The top two phase bits choose the quadrant, the rest is rotated.
            assign src_x[s][l] = CORDIC_GAIN;
            assign src_y[s][l] = '0;
            assign src_z[s][l] = signed'({2'b00, phase[l][PH_W-3:0]});
            assign src_q[s][l] = phase[l][PH_W-1:PH_W-2];
         end else begin : g_next
            assign src_x[s][l] = x_ff[s-1][l];
            assign src_y[s][l] = y_ff[s-1][l];
            assign src_z[s][l] = z_ff[s-1][l];
            assign src_q[s][l] = quad_ff[s-1][l];
         end
      end

      always_comb begin
         logic signed [CX_W-1:0] x;
         logic signed [CX_W-1:0] y;
         logic signed [CX_W-1:0] dx;
         logic signed [CX_W-1:0] dy;
         logic signed [PH_W-1:0] z;
         for (int l = 0; l < 2; l++) begin
            x = src_x[s][l];
            y = src_y[s][l];
            z = src_z[s][l];
            for (int m = 0; m < CORDIC_PER_ST; m++) begin
               dx = y >>> (s * CORDIC_PER_ST + m);
               dy = x >>> (s * CORDIC_PER_ST + m);
               if (!z[PH_W-1]) begin
                  x = x - dx;
                  y = y + dy;
                  z = z - atan_entry(s * CORDIC_PER_ST + m);
               end else begin
                  x = x + dx;
                  y = y - dy;
                  z = z + atan_entry(s * CORDIC_PER_ST + m);
               end
            end
            x_in[s][l] = x;
            y_in[s][l] = y;
            z_in[s][l] = z;
         end
      end
   end

   always_comb begin
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      for (int l = 0; l < 2; l++) begin
         x = x_ff[CORDIC_STAGES-1][l];
         y = y_ff[CORDIC_STAGES-1][l];
         case (quad_ff[CORDIC_STAGES-1][l])
            2'd0: begin
               cos_in[l] = TRIG_W'(x);
               sin_in[l] = TRIG_W'(y);
            end
            2'd1: begin
               cos_in[l] = TRIG_W'(-y);
               sin_in[l] = TRIG_W'(x);
            end
            2'd2: begin
               cos_in[l] = TRIG_W'(-x);
               sin_in[l] = TRIG_W'(-y);
            end
            default: begin
               cos_in[l] = TRIG_W'(y);
               sin_in[l] = TRIG_W'(-x);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff       <= x_in;
         y_ff       <= y_in;
         z_ff       <= z_in;
         cos_ff     <= cos_in;
         sin_ff     <= sin_in;
         side_ff[0] <= side_in;
         for (int s = 0; s < CORDIC_STAGES; s++) begin
            for (int l = 0; l < 2; l++) begin
               quad_ff[s][l] <= src_q[s][l];
            end
         end
         for (int s = 1; s < NST; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_vld  = vld_ff[NST-1];
   assign cos_out  = cos_ff;
   assign sin_out  = sin_ff;
   assign side_out = side_ff[NST-1];

endmodule

`default_nettype wire

// ===== rtl/core/uvsg_prod.sv =====
// ----------------------------------------------------------------------------
// Vertex product stages
// Forms the trig products, scales by the radius and rounds and saturates the
// position and normal; the last stage is the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module uvsg_prod (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_vld,
   input  logic signed [uvsg_pkg::TRIG_W-1:0]   cu,
   input  logic signed [uvsg_pkg::TRIG_W-1:0]   su,
   input  logic signed [uvsg_pkg::TRIG_W-1:0]   cv,
   input  logic signed [uvsg_pkg::TRIG_W-1:0]   sv,
   input  logic [uvsg_pkg::RAD_W-1:0]           radius,
   input  uvsg_pkg::vtx_side_type               side_in,
   output logic                                 out_vld,
   output logic signed [uvsg_pkg::OUT_W-1:0]    pos_x,
   output logic signed [uvsg_pkg::OUT_W-1:0]    pos_y,
   output logic signed [uvsg_pkg::OUT_W-1:0]    pos_z,
   output logic signed [uvsg_pkg::OUT_W-1:0]    norm_x,
   output logic signed [uvsg_pkg::OUT_W-1:0]    norm_y,
   output logic signed [uvsg_pkg::OUT_W-1:0]    norm_z,
   output uvsg_pkg::vtx_side_type               side_out
);
   import uvsg_pkg::*;

   localparam int NST   = 4;
   localparam int TX_W  = 33;
   localparam int PR_W  = 49;
   localparam logic signed [63:0] HALF30 = 64'sd536870912;
   localparam logic signed [63:0] HALF15 = 64'sd16384;

   logic [NST-1:0]            vld_ff;
   vtx_side_type              side_ff [NST];
   logic signed [63:0]        pc_ff, pc_in, ps_ff, ps_in;
   logic signed [TRIG_W-1:0]  su0_ff, su1_ff;
   logic signed [TX_W-1:0]    tx_ff, tx_in, ty_ff, ty_in;
   logic signed [15:0]        rad_s;
   logic signed [PR_W-1:0]    px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [OUT_W-1:0]   nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;
   logic signed [OUT_W-1:0]   nx2_ff, ny2_ff, nz2_ff;
   logic signed [OUT_W-1:0]   qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in;

   assign rad_s = signed'({1'b0, radius});

   always_comb begin
      pc_in = cu * cv;
      ps_in = cu * sv;
      tx_in = TX_W'((pc_ff + HALF30) >>> 30);
      ty_in = TX_W'((ps_ff + HALF30) >>> 30);
      px_in = rad_s * tx_ff;
      py_in = rad_s * ty_ff;
      pz_in = rad_s * su1_ff;
      nx_in = sat16((64'(tx_ff) + HALF15) >>> 15);
      ny_in = sat16((64'(ty_ff) + HALF15) >>> 15);
      nz_in = sat16((64'(su1_ff) + HALF15) >>> 15);
      qx_in = sat16((64'(px_ff) + HALF30) >>> 30);
      qy_in = sat16((64'(py_ff) + HALF30) >>> 30);
      qz_in = sat16((64'(pz_ff) + HALF30) >>> 30);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pc_ff      <= pc_in;
         ps_ff      <= ps_in;
         su0_ff     <= su;
         tx_ff      <= tx_in;
         ty_ff      <= ty_in;
         su1_ff     <= su0_ff;
         px_ff      <= px_in;
         py_ff      <= py_in;
         pz_ff      <= pz_in;
         nx_ff      <= nx_in;
         ny_ff      <= ny_in;
         nz_ff      <= nz_in;
         qx_ff      <= qx_in;
         qy_ff      <= qy_in;
         qz_ff      <= qz_in;
         nx2_ff     <= nx_ff;
         ny2_ff     <= ny_ff;
         nz2_ff     <= nz_ff;
         side_ff[0] <= side_in;
         for (int s = 1; s < NST; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_vld  = vld_ff[NST-1];
   assign pos_x    = qx_ff;
   assign pos_y    = qy_ff;
   assign pos_z    = qz_ff;
   assign norm_x   = nx2_ff;
   assign norm_y   = ny2_ff;
   assign norm_z   = nz2_ff;
   assign side_out = side_ff[NST-1];

endmodule

`default_nettype wire

// ===== rtl/core/uv_sphere_vertex_generator_unit.sv =====
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Gives position, normal, texture coordinates, quad indices and triangle
// flags for one grid point of a UV sphere.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  req      in         tdata: stack_index, sector_index
//  rsp      out        tdata: pos, normal, tex, bases; tuser: triangle flags
//  csr      in         write only: radius, sector_count, stack_count
//
// One request enters per cycle while the pipeline is not held; its result reaches
// rsp through 26 register stages: the input register, 9 divider stages, the
// phase register, 11 CORDIC stages and 4 product stages.
// Reset clears the valid bits and loads the register defaults.
// When a result waits and rsp_tready is low the whole pipeline holds.
// ----------------------------------------------------------------------------
`default_nettype none

module uv_sphere_vertex_generator_unit #(
   parameter int MAX_COUNT = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // stack_index, sector_index
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, tex_t,
   // row_base, next_row_base
   output logic [167:0]                      rsp_tdata,
   output logic [1:0]                        rsp_tuser,  // upper_tri_valid, lower_tri_valid
   input  logic                              csr_we,
   input  logic [uvsg_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [uvsg_pkg::CSR_W-1:0]        csr_wdata
);
   import uvsg_pkg::*;

   localparam logic [10:0] MAX_C = 11'(MAX_COUNT);

   logic                    adv;
   logic [RAD_W-1:0]        radius_ff;
   logic [CNT_W-1:0]        sectors_ff, stacks_ff;
   logic [CNT_W-1:0]        s_eff, t_eff, i_c, j_c;
   logic [CNT_W:0]          s1;
   logic [19:0]             base_full;
   logic                    quad;
   mesh_type                mesh_in;

   logic                    in_vld_ff;
   logic [1:0][CNT_W-1:0]   num_ff, den_ff;
   mesh_type                mesh_ff;

   logic                    div_vld;
   logic [1:0][QUO_W-1:0]   quo;
   mesh_type                div_mesh;

   logic                    ph_vld_ff;
   logic [1:0][PH_W-1:0]    ph_ff, ph_in;
   vtx_side_type            side_ff, side_in;

   logic                    cor_vld;
   logic signed [TRIG_W-1:0] cos_v [2];
   logic signed [TRIG_W-1:0] sin_v [2];
   vtx_side_type            cor_side;

   logic signed [OUT_W-1:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z;
   vtx_side_type            out_side;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= RADIUS_RST;
         sectors_ff <= SECTORS_RST;
         stacks_ff  <= STACKS_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_RADIUS:  radius_ff  <= csr_wdata[RAD_W-1:0];
            CSR_SECTORS: sectors_ff <= csr_wdata[CNT_W-1:0];
            CSR_STACKS:  stacks_ff  <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp counts and indices, and work out the quad indices and flags.
   always_comb begin
      if ({2'b00, sectors_ff} < 11'd3) begin
         s_eff = 9'd3;
      end else if ({2'b00, sectors_ff} > MAX_C) begin
         s_eff = MAX_C[CNT_W-1:0];
      end else begin
         s_eff = sectors_ff;
      end
      if ({2'b00, stacks_ff} < 11'd2) begin
         t_eff = 9'd2;
      end else if ({2'b00, stacks_ff} > MAX_C) begin
         t_eff = MAX_C[CNT_W-1:0];
      end else begin
         t_eff = stacks_ff;
      end
      i_c = (req_tdata[8:0] > t_eff) ? t_eff : req_tdata[8:0];
      j_c = (req_tdata[17:9] > s_eff) ? s_eff : req_tdata[17:9];
      s1        = {1'b0, s_eff} + 10'd1;
      base_full = 20'(i_c) * 20'(s1) + 20'(j_c);
      quad      = (i_c < t_eff) && (j_c < s_eff);
      mesh_in.row_base        = base_full[BASE_W-1:0];
      mesh_in.next_row_base   = 17'(base_full + 20'(s1));
      mesh_in.upper_tri_valid = quad && (i_c != 9'd0);
      mesh_in.lower_tri_valid = quad && (i_c != t_eff - 9'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         ph_vld_ff <= 1'b0;
      end else if (adv) begin
         in_vld_ff <= req_tvalid;
         ph_vld_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff[LANE_STACK]  <= i_c;
         num_ff[LANE_SECTOR] <= j_c;
         den_ff[LANE_STACK]  <= t_eff;
         den_ff[LANE_SECTOR] <= s_eff;
         mesh_ff             <= mesh_in;
         ph_ff               <= ph_in;
         side_ff             <= side_in;
      end
   end

   uvsg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (in_vld_ff),
      .num      (num_ff),
      .den      (den_ff),
      .mesh_in  (mesh_ff),
      .out_vld  (div_vld),
      .quo      (quo),
      .mesh_out (div_mesh)
   );

   // Rounded phases and texture coordinates from the quotients n*2^36/d.
   always_comb begin
      logic [34:0] sec_r;
      logic [33:0] st_r;
      sec_r = (35'(quo[LANE_SECTOR][QUO_W-1:3]) + 35'd1) >> 1;
      st_r  = (34'(quo[LANE_STACK][QUO_W-1:4]) + 34'd1) >> 1;
      ph_in[LANE_SECTOR] = sec_r[PH_W-1:0];
      ph_in[LANE_STACK]  = 32'h4000_0000 - st_r[PH_W-1:0];
      side_in.mesh  = div_mesh;
      side_in.tex_s = 17'((19'(quo[LANE_SECTOR][QUO_W-1:19]) + 19'd1) >> 1);
      side_in.tex_t = 17'((19'(quo[LANE_STACK][QUO_W-1:19]) + 19'd1) >> 1);
   end

   uvsg_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (ph_vld_ff),
      .phase    (ph_ff),
      .side_in  (side_ff),
      .out_vld  (cor_vld),
      .cos_out  (cos_v),
      .sin_out  (sin_v),
      .side_out (cor_side)
   );

   uvsg_prod u_prod (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (cor_vld),
      .cu       (cos_v[LANE_STACK]),
      .su       (sin_v[LANE_STACK]),
      .cv       (cos_v[LANE_SECTOR]),
      .sv       (sin_v[LANE_SECTOR]),
      .radius   (radius_ff),
      .side_in  (cor_side),
      .out_vld  (rsp_tvalid),
      .pos_x    (pos_x),
      .pos_y    (pos_y),
      .pos_z    (pos_z),
      .norm_x   (norm_x),
      .norm_y   (norm_y),
      .norm_z   (norm_z),
      .side_out (out_side)
   );

   assign rsp_tdata = {4'b0000, out_side.mesh.next_row_base, out_side.mesh.row_base,
                       out_side.tex_t, out_side.tex_s,
                       norm_z, norm_y, norm_x, pos_z, pos_y, pos_x};
   assign rsp_tuser = {out_side.mesh.lower_tri_valid, out_side.mesh.upper_tri_valid};

endmodule

`default_nettype wire

// ===== bench/tb_uv_sphere_vertex_generator_unit.sv =====
// ----------------------------------------------------------------------------
// UV sphere vertex generator testbench
// Drives grid points through the request stream under several register
// settings and idle patterns. A local predictor works out position, normal,
// texture coordinates, quad indices and triangle flags for each request, and
// the monitor checks every result field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_uv_sphere_vertex_generator_unit;
   import uvsg_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;
   localparam int MAX_CNT  = 256;
   localparam int LATENCY  = 26;
   localparam int NFIELDS  = 12;

   typedef logic [NFIELDS-1:0][16:0] vertex_fields_type;
   typedef struct packed {
      logic [8:0] stack_idx;
      logic [8:0] sector_idx;
   } grid_point_type;

   logic         clock, reset;
   logic         req_tvalid, req_tready;
   logic [23:0]  req_tdata;
   logic         rsp_tvalid, rsp_tready;
   logic [167:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_W-1:0]      csr_wdata;

   uv_sphere_vertex_generator_unit uut (.*);

   string field_name [NFIELDS] = '{"pos_x", "pos_y", "pos_z", "norm_x", "norm_y", "norm_z",
                                   "tex_s", "tex_t", "row_base", "next_row_base",
                                   "upper_tri_valid", "lower_tri_valid"};

   // Register copy used by the predictor.
   longint radius_q, sectors_q, stacks_q;

   grid_point_type    point_queue [$];
   vertex_fields_type vertex_expected [$];
   int  send_idle_pct, recv_stall_pct, hold_left;
   bit  req_taken;
   int  errors, n_sent, n_checked, n_settings;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Timeout at %0t", $time);
      $display("FAIL uv_sphere_vertex_generator_unit");
      $finish;
   end

   function automatic longint round_sh(longint v, int k);
      return (v + (longint'(1) << (k - 1))) >>> k;
   endfunction

   function automatic longint sat_word(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Quadrant fold around a 20-step rotation CORDIC, results at scale 2^30.
   task automatic phase_trig(input logic [31:0] ph, output longint c, output longint s);
      longint x, y, z, dx, dy, ang;
      x = 652032874;
      y = 0;
      z = ph[29:0];
      for (int k = 0; k < 20; k++) begin
         dx  = y >>> k;
         dy  = x >>> k;
         ang = atan_entry(k);
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - ang;
         end else begin
            x = x + dx; y = y - dy; z = z + ang;
         end
      end
      case (ph[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   task automatic predict_vertex(input grid_point_type p, output vertex_fields_type f);
      longint secs, stks, i, j, cu, su, cv, sv, tx, ty, base;
      logic [31:0] ph_sec, ph_st;
      logic quad;
      secs = sectors_q < 3 ? 3 : (sectors_q > MAX_CNT ? MAX_CNT : sectors_q);
      stks = stacks_q < 2 ? 2 : (stacks_q > MAX_CNT ? MAX_CNT : stacks_q);
      i = p.stack_idx > stks ? stks : p.stack_idx;
      j = p.sector_idx > secs ? secs : p.sector_idx;
      ph_sec = 32'(((j << 32) + secs / 2) / secs);
      ph_st  = 32'h4000_0000 - 32'(((i << 31) + stks / 2) / stks);
      phase_trig(ph_st, cu, su);
      phase_trig(ph_sec, cv, sv);
      tx = round_sh(cu * cv, 30);
      ty = round_sh(cu * sv, 30);
      // Words are compared as 16-bit patterns with a zero top bit.
      f[0]  = {1'b0, 16'(sat_word(round_sh(radius_q * tx, 30)))};
      f[1]  = {1'b0, 16'(sat_word(round_sh(radius_q * ty, 30)))};
      f[2]  = {1'b0, 16'(sat_word(round_sh(radius_q * su, 30)))};
      f[3]  = {1'b0, 16'(sat_word(round_sh(tx, 15)))};
      f[4]  = {1'b0, 16'(sat_word(round_sh(ty, 15)))};
      f[5]  = {1'b0, 16'(sat_word(round_sh(su, 15)))};
      f[6]  = 17'((j * 65536 + secs / 2) / secs);
      f[7]  = 17'((i * 65536 + stks / 2) / stks);
      base  = i * (secs + 1) + j;
      f[8]  = 17'(base);
      f[9]  = 17'(base + secs + 1);
      quad  = (i < stks) && (j < secs);
      f[10] = 17'(quad && i != 0);
      f[11] = 17'(quad && i != stks - 1);
   endtask

   // Request driver.
   always @(negedge clock) begin
      grid_point_type p;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_taken)) begin
         if (point_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            p = point_queue.pop_front();
            req_tdata  <= {6'd0, p.sector_idx, p.stack_idx};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver, with an optional long hold-off.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   // Prediction on acceptance and checking of results.
   always @(posedge clock) begin
      vertex_fields_type exp_f, act_f;
      grid_point_type    p;
      req_taken <= req_tvalid && req_tready && !reset;
      if (!reset && req_tvalid && req_tready) begin
         p.stack_idx  = req_tdata[8:0];
         p.sector_idx = req_tdata[17:9];
         predict_vertex(p, exp_f);
         vertex_expected.insert(vertex_expected.size(), exp_f);
         n_sent++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         for (int k = 0; k < 6; k++) act_f[k] = 17'(rsp_tdata[16*k +: 16]);
         act_f[6]  = rsp_tdata[96 +: 17];
         act_f[7]  = rsp_tdata[113 +: 17];
         act_f[8]  = rsp_tdata[130 +: 17];
         act_f[9]  = rsp_tdata[147 +: 17];
         act_f[10] = 17'(rsp_tuser[0]);
         act_f[11] = 17'(rsp_tuser[1]);
         if (vertex_expected.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual tdata %h", $time,
                     rsp_tdata);
            errors++;
         end else begin
            exp_f = vertex_expected.pop_front();
            n_checked++;
            for (int k = 0; k < NFIELDS; k++) begin
               if (act_f[k] !== exp_f[k]) begin
                  $display("%0t: %s expected %h actual %h", $time, field_name[k],
                           exp_f[k], act_f[k]);
                  errors++;
               end
            end
         end
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] a, input int v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= CSR_W'(v);
      @(negedge clock);
      csr_we    <= 1'b0;
      case (a)
         CSR_RADIUS:  radius_q  = v & 16'h7FFF;
         CSR_SECTORS: sectors_q = v & 9'h1FF;
         CSR_STACKS:  stacks_q  = v & 9'h1FF;
         default: ;
      endcase
   endtask

   // Checked at clock edges so that a request just taken from the queue is seen.
   task automatic drain;
      do @(posedge clock);
      while (point_queue.size() != 0 || req_tvalid || vertex_expected.size() != 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
         default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
   endtask

   task automatic queue_point(input logic [8:0] i, input logic [8:0] j);
      grid_point_type p;
      p.stack_idx  = i;
      p.sector_idx = j;
      point_queue.insert(point_queue.size(), p);
   endtask

   // Mostly legal grid points, now and then any 9-bit index.
   task automatic queue_random(input int n);
      int secs, stks;
      secs = sectors_q < 3 ? 3 : (sectors_q > MAX_CNT ? MAX_CNT : int'(sectors_q));
      stks = stacks_q < 2 ? 2 : (stacks_q > MAX_CNT ? MAX_CNT : int'(stacks_q));
      repeat (n) begin
         if ($urandom_range(9) == 0) begin
            queue_point(9'($urandom_range(511)), 9'($urandom_range(511)));
         end else begin
            queue_point(9'($urandom_range(stks)), 9'($urandom_range(secs)));
         end
      end
   endtask

   initial begin
      int s;
      reset = 1'b1; req_tvalid = 1'b0; req_tdata = '0; rsp_tready = 1'b0;
      csr_we = 1'b0; csr_addr = '0; csr_wdata = '0; req_taken = 1'b0;
      hold_left = 0; send_idle_pct = 0; recv_stall_pct = 0;
      errors = 0; n_sent = 0; n_checked = 0; n_settings = 1;
      radius_q = 4506; sectors_q = 36; stacks_q = 18;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed points at the default registers: poles, last row, seam, clamps.
      queue_point(9'd0, 9'd0);
      queue_point(9'd0, 9'd35);
      queue_point(9'd1, 9'd0);
      queue_point(9'd9, 9'd9);
      queue_point(9'd9, 9'd18);
      queue_point(9'd9, 9'd27);
      queue_point(9'd17, 9'd5);
      queue_point(9'd18, 9'd5);
      queue_point(9'd5, 9'd36);
      queue_point(9'd18, 9'd36);
      queue_point(9'd511, 9'd511);
      queue_point(9'd256, 9'd1);
      queue_point(9'd3, 9'd300);
      queue_point(9'h155, 9'h0AA);
      queue_point(9'h0AA, 9'h155);
      drain();

      // Edge settings, then random ones; the spare index must be ignored.
      for (s = 0; s < 12; s++) begin
         case (s)
            0: begin csr_write(CSR_RADIUS, 0); csr_write(CSR_SECTORS, 3);
                     csr_write(CSR_STACKS, 2); end
            1: begin csr_write(CSR_RADIUS, 32767); csr_write(CSR_SECTORS, 256);
                     csr_write(CSR_STACKS, 256); end
            2: begin csr_write(CSR_SECTORS, 0); csr_write(CSR_STACKS, 511);
                     csr_write(CSR_SPARE, 32767); end
            3: begin csr_write(CSR_SECTORS, 511); csr_write(CSR_STACKS, 1);
                     csr_write(CSR_RADIUS, 16384); end
            4: begin csr_write(CSR_RADIUS, 4506); csr_write(CSR_SECTORS, 36);
                     csr_write(CSR_STACKS, 18); end
            default: begin
               csr_write(CSR_RADIUS, $urandom_range(32767));
               csr_write(CSR_SECTORS, $urandom_range(511));
               csr_write(CSR_STACKS, $urandom_range(511));
            end
         endcase
         n_settings++;
         set_idling(s);
         queue_random(65);
         // A long receiver hold-off so the pipeline fills and back-pressures.
         if (s == 5) begin
            @(posedge clock);
            hold_left = 200;
         end
         drain();
      end

      $display("Checked %0d of %0d requests over %0d register settings,", n_checked,
               n_sent, n_settings);
      $display("with poles, seam, clamped indices and counts, and four idle patterns.");
      if (errors == 0 && vertex_expected.size() == 0) begin
         $display("PASS uv_sphere_vertex_generator_unit");
      end else begin
         $display("FAIL uv_sphere_vertex_generator_unit");
      end
      $finish;
   end

endmodule

`default_nettype wire
